// ----- rtl/bwr_pkg.sv -----
`timescale 1ns / 1ps
package bwr_pkg;

    localparam int MAX_LEN = 64;
    localparam int LEN_W   = $clog2(MAX_LEN + 1);
    localparam int IDX_W   = $clog2(MAX_LEN);
    localparam int EXT_W   = LEN_W + 1;

    typedef logic signed [7:0] elem_t;
    typedef logic [6:0]        mag_t;

    // request codes
    localparam logic [3:0] RQ_CLEAR  = 4'd0;
    localparam logic [3:0] RQ_APPEND = 4'd1;
    localparam logic [3:0] RQ_READ   = 4'd2;
    localparam logic [3:0] RQ_ROTL   = 4'd3;
    localparam logic [3:0] RQ_ROTR   = 4'd4;
    localparam logic [3:0] RQ_REL1   = 4'd5;
    localparam logic [3:0] RQ_REL2   = 4'd6;
    localparam logic [3:0] RQ_CONJ   = 4'd7;
    localparam logic [3:0] RQ_STAB   = 4'd8;
    localparam logic [3:0] RQ_DESTAB = 4'd9;
    localparam logic [3:0] RQ_PAIR   = 4'd10;
    localparam logic [3:0] RQ_TEST   = 4'd11;
    localparam logic [3:0] RQ_LIST   = 4'd12;

    // status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOPERF = 2'd1;
    localparam logic [1:0] ST_BADIDX = 2'd2;
    localparam logic [1:0] ST_OVF    = 2'd3;

    typedef enum logic [1:0] {
        CK_REL1,
        CK_REL2,
        CK_DESTAB,
        CK_PAIR
    } ck_t;

    typedef struct packed {
        logic [3:0] req_type;
        logic [6:0] position;
        elem_t      gen_value;
        logic [1:0] check_kind;
        logic       top_side;
        logic       inverse_gen;
        logic [6:0] strands;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic       flag;
        elem_t      elem_value;
        logic [6:0] word_length;
        logic       last;
    } rsp_t;

    // one command to the cell chain per cycle
    typedef struct packed {
        logic             shift;
        logic             wr;
        logic [IDX_W-1:0] idx;
        elem_t            data;
    } chain_cmd_t;

    function automatic mag_t mag(elem_t x);
        logic [7:0] t;
        t = x[7] ? 8'(-x) : 8'(x);
        return t[6:0];
    endfunction

    function automatic elem_t signed_mag(logic neg, mag_t m);
        elem_t t;
        t = elem_t'({1'b0, m});
        return neg ? elem_t'(-t) : t;
    endfunction

    // performability of a move with the window a, b, c at its position
    function automatic logic chk(ck_t kind, elem_t a, elem_t b, elem_t c,
                                 logic [LEN_W-1:0] n, logic [6:0] strands,
                                 logic [1:0] cnt_b, logic [1:0] cnt_t);
        mag_t ma;
        mag_t mb;
        mag_t mc;
        logic r1;
        logic r2;
        logic dst;
        logic pr;
        logic res;
        ma  = mag(a);
        mb  = mag(b);
        mc  = mag(c);
        r1  = (n >= LEN_W'(3)) && (ma == mc)
            && ((8'(mb) == 8'(ma) + 8'd1) || (8'(ma) == 8'(mb) + 8'd1))
            && !((b[7] != a[7]) && (b[7] != c[7]));
        r2  = (ma >= mb) ? ((ma - mb) >= 7'd2) : ((mb - ma) >= 7'd2);
        dst = ((strands != 7'd0) && (ma == strands - 7'd1) && (cnt_b == 2'd1))
            || ((ma == 7'd1) && (cnt_t == 2'd1));
        pr  = (a == elem_t'(-b));
        case (kind)
            CK_REL1:   res = r1;
            CK_REL2:   res = r2;
            CK_DESTAB: res = dst;
            default:   res = pr;
        endcase
        return res;
    endfunction

endpackage

// ----- rtl/braid_word_rewrite_engine_core.sv -----
`timescale 1ns / 1ps
// Braid word rewrite engine. The word sits in a row of cells with element 0 at
// the head; scans, rewrites and rotations turn the word through the head, one
// element per cycle. Clear and append respond without a turn. Read, test,
// relation, conjugate, stabilize, destabilize and pair removal first scan the
// word (n the word length) to look at the neighborhood of the position and
// count magnitudes; moves that pass their checks then rewrite it in a second
// turn, which pauses for each inserted element. Rotation reduces the amount
// modulo n by repeated subtraction, then turns the word one step at a time,
// up to n-1 steps, and then responds. A list request scans once and then
// gives one flagged beat per cycle while the output is not stalled. Only one
// request is in flight; the next is taken when the last beat of the current
// one sits in the output register.
module braid_word_rewrite_engine_core
    import bwr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_ROT,
        S_SCAN,
        S_WORK,
        S_RESP
    } state_t;

    state_t           state_reg, state_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [LEN_W-1:0] n_reg, n_next;
    logic [LEN_W-1:0] k_reg, k_next;
    logic [LEN_W-1:0] rc_reg, rc_next;
    logic [1:0]       ins_reg, ins_next;
    logic [6:0]       r_reg, r_next;
    logic [3:0]       rq_reg, rq_next;
    logic [6:0]       pos_reg, pos_next;
    elem_t            gv_reg, gv_next;
    ck_t              kind_reg, kind_next;
    logic             top_reg, top_next;
    logic             inv_reg, inv_next;
    logic [6:0]       strands_reg, strands_next;
    logic [1:0]       st_reg, st_next;
    logic             fl_reg, fl_next;
    elem_t            el_reg, el_next;
    elem_t            a_reg, a_next;
    elem_t            b_reg, b_next;
    elem_t            c_reg, c_next;
    logic [1:0]       cntb_reg, cntb_next;
    logic [1:0]       cntt_reg, cntt_next;
    logic             big_reg, big_next;
    logic             rsp_valid_reg, rsp_valid_next;
    rsp_t             rsp_reg, rsp_next;

    chain_cmd_t       cmd;
    elem_t            head, nb1_raw, nb1, nb2;
    logic             slot_free;
    logic             gv_ok;
    logic             pf;
    ck_t              op_kind;
    logic [LEN_W-1:0] j_idx, i2_idx;
    logic             k_is_pos, k_is_j, k_is_i2;
    logic [1:0]       need;
    elem_t            ins_val;
    logic             pop;
    elem_t            rot_val;
    elem_t            x0, x1, x2;
    mag_t             mh;
    logic             wrap;

    bwr_chain u_chain (
        .clk  (clk),
        .cmd  (cmd),
        .head (head),
        .nb1  (nb1_raw),
        .nb2  (nb2)
    );

    // a one-element word is its own successor
    assign nb1       = (len_reg == LEN_W'(1)) ? head : nb1_raw;
    assign slot_free = !rsp_valid_reg || !rsp_stall;
    assign gv_ok     = (req.gen_value != 8'sd0) && (req.gen_value != -8'sd128);
    assign mh        = mag(head);

    // cyclic successors of the position
    always_comb
    begin
        if (EXT_W'(pos_reg) + EXT_W'(1) == EXT_W'(n_reg))
        begin
            j_idx = '0;
        end
        else
        begin
            j_idx = LEN_W'(pos_reg) + LEN_W'(1);
        end
        if (j_idx + LEN_W'(1) == n_reg)
        begin
            i2_idx = '0;
        end
        else
        begin
            i2_idx = j_idx + LEN_W'(1);
        end
    end

    assign k_is_pos = (EXT_W'(k_reg) == EXT_W'(pos_reg));
    assign k_is_j   = (k_reg == j_idx);
    assign k_is_i2  = (k_reg == i2_idx);

    // move kind that a rewrite request checks
    always_comb
    begin
        case (rq_reg)
            RQ_REL1:   op_kind = CK_REL1;
            RQ_REL2:   op_kind = CK_REL2;
            RQ_DESTAB: op_kind = CK_DESTAB;
            RQ_PAIR:   op_kind = CK_PAIR;
            default:   op_kind = kind_reg;
        endcase
    end

    assign pf = chk(op_kind, a_reg, b_reg, c_reg, n_reg, strands_reg, cntb_reg, cntt_reg);

    // relation 1 replacement values
    assign x0 = signed_mag(c_reg[7], mag(b_reg));
    assign x1 = signed_mag(b_reg[7], mag(a_reg));
    assign x2 = signed_mag(a_reg[7], mag(b_reg));

    assign wrap = (EXT_W'(pos_reg) == EXT_W'(n_reg) + EXT_W'(1));

    // insertions due before original element k
    always_comb
    begin
        need    = 2'd0;
        ins_val = gv_reg;
        case (rq_reg)
            RQ_CONJ:
            begin
                if (wrap)
                begin
                    need    = 2'((k_reg == '0) ? 1 : 0) + 2'((k_reg == n_reg) ? 1 : 0);
                    ins_val = ((k_reg == '0) && (ins_reg == 2'd0)) ? elem_t'(-gv_reg) : gv_reg;
                end
                else
                begin
                    need    = k_is_pos ? 2'd2 : 2'd0;
                    ins_val = (ins_reg == 2'd0) ? gv_reg : elem_t'(-gv_reg);
                end
            end
            RQ_STAB:
            begin
                need = k_is_pos ? 2'd1 : 2'd0;
                if (top_reg)
                begin
                    ins_val = inv_reg ? -8'sd1 : 8'sd1;
                end
                else
                begin
                    ins_val = signed_mag(inv_reg, strands_reg);
                end
            end
            default:
            begin
                need = 2'd0;
            end
        endcase
    end

    // removal and rewritten value of original element k
    always_comb
    begin
        pop     = 1'b0;
        rot_val = head;
        case (rq_reg)
            RQ_REL1:
            begin
                if (k_is_pos)
                begin
                    rot_val = x0;
                end
                else if (k_is_j)
                begin
                    rot_val = x1;
                end
                else if (k_is_i2)
                begin
                    rot_val = x2;
                end
            end
            RQ_REL2:
            begin
                if (k_is_pos)
                begin
                    rot_val = b_reg;
                end
                else if (k_is_j)
                begin
                    rot_val = a_reg;
                end
            end
            RQ_STAB:
            begin
                if (top_reg)
                begin
                    rot_val = head[7] ? head - 8'sd1 : head + 8'sd1;
                end
            end
            RQ_DESTAB:
            begin
                pop = k_is_pos;
                if (mag(a_reg) == 7'd1)
                begin
                    rot_val = head[7] ? head + 8'sd1 : head - 8'sd1;
                end
            end
            RQ_PAIR:
            begin
                pop = k_is_pos || k_is_j;
            end
            default:
            begin
                rot_val = head;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        rc_next        = rc_reg;
        ins_next       = ins_reg;
        r_next         = r_reg;
        rq_next        = rq_reg;
        pos_next       = pos_reg;
        gv_next        = gv_reg;
        kind_next      = kind_reg;
        top_next       = top_reg;
        inv_next       = inv_reg;
        strands_next   = strands_reg;
        st_next        = st_reg;
        fl_next        = fl_reg;
        el_next        = el_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        cntb_next      = cntb_reg;
        cntt_next      = cntt_reg;
        big_next       = big_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        cmd            = '0;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    rq_next      = req.req_type;
                    pos_next     = req.position;
                    gv_next      = req.gen_value;
                    kind_next    = ck_t'(req.check_kind);
                    top_next     = req.top_side;
                    inv_next     = req.inverse_gen;
                    strands_next = req.strands;
                    n_next       = len_reg;
                    k_next       = '0;
                    ins_next     = 2'd0;
                    r_next       = req.position;
                    st_next      = ST_OK;
                    fl_next      = 1'b0;
                    el_next      = '0;
                    cntb_next    = 2'd0;
                    cntt_next    = 2'd0;
                    big_next     = 1'b0;
                    state_next   = S_RESP;
                    unique case (req.req_type) inside
                        RQ_CLEAR:
                        begin
                            len_next = '0;
                        end
                        RQ_APPEND:
                        begin
                            if ((EXT_W'(len_reg) >= EXT_W'(MAX_LEN)) || !gv_ok)
                            begin
                                st_next = ST_OVF;
                            end
                            else
                            begin
                                cmd.wr   = 1'b1;
                                cmd.idx  = IDX_W'(len_reg);
                                cmd.data = req.gen_value;
                                len_next = len_reg + LEN_W'(1);
                            end
                        end
                        RQ_ROTL, RQ_ROTR:
                        begin
                            if (len_reg != '0)
                            begin
                                state_next = S_MOD;
                            end
                        end
                        RQ_READ, RQ_REL1, RQ_REL2, RQ_DESTAB, RQ_PAIR, RQ_TEST:
                        begin
                            if (EXT_W'(req.position) >= EXT_W'(len_reg))
                            begin
                                st_next = ST_BADIDX;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        RQ_CONJ:
                        begin
                            if (EXT_W'(req.position) > EXT_W'(len_reg) + EXT_W'(1))
                            begin
                                st_next = ST_BADIDX;
                            end
                            else if ((EXT_W'(len_reg) + EXT_W'(2) > EXT_W'(MAX_LEN)) || !gv_ok)
                            begin
                                st_next = ST_OVF;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        RQ_STAB:
                        begin
                            if (EXT_W'(req.position) > EXT_W'(len_reg))
                            begin
                                st_next = ST_BADIDX;
                            end
                            else if ((EXT_W'(len_reg) + EXT_W'(1) > EXT_W'(MAX_LEN))
                                     || (!req.top_side && (req.strands == 7'd0)))
                            begin
                                st_next = ST_OVF;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        RQ_LIST:
                        begin
                            if (len_reg != '0)
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            st_next = ST_NOPERF;
                        end
                    endcase
                end
            end

            // rotation amount modulo the length
            S_MOD:
            begin
                if (EXT_W'(r_reg) >= EXT_W'(n_reg))
                begin
                    r_next = r_reg - 7'(n_reg);
                end
                else
                begin
                    if (rq_reg == RQ_ROTL)
                    begin
                        rc_next = LEN_W'(r_reg);
                    end
                    else
                    begin
                        rc_next = (r_reg == 7'd0) ? '0 : n_reg - LEN_W'(r_reg);
                    end
                    k_next     = '0;
                    state_next = S_ROT;
                end
            end

            S_ROT:
            begin
                if (k_reg == rc_reg)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    cmd.shift = 1'b1;
                    cmd.wr    = 1'b1;
                    cmd.idx   = IDX_W'(len_reg - LEN_W'(1));
                    cmd.data  = head;
                    k_next    = k_reg + LEN_W'(1);
                end
            end

            // full turn: capture the window at the position, count magnitudes
            S_SCAN:
            begin
                if (k_reg == n_reg)
                begin
                    k_next     = '0;
                    ins_next   = 2'd0;
                    state_next = S_WORK;
                    case (rq_reg) inside
                        RQ_READ:
                        begin
                            el_next    = a_reg;
                            state_next = S_RESP;
                        end
                        RQ_TEST:
                        begin
                            fl_next    = pf;
                            state_next = S_RESP;
                        end
                        RQ_REL1, RQ_REL2, RQ_DESTAB, RQ_PAIR:
                        begin
                            if (!pf)
                            begin
                                st_next    = ST_NOPERF;
                                state_next = S_RESP;
                            end
                        end
                        RQ_STAB:
                        begin
                            if (top_reg && big_reg)
                            begin
                                st_next    = ST_OVF;
                                state_next = S_RESP;
                            end
                        end
                        default:
                        begin
                            state_next = S_WORK;
                        end
                    endcase
                end
                else
                begin
                    cmd.shift = 1'b1;
                    cmd.wr    = 1'b1;
                    cmd.idx   = IDX_W'(len_reg - LEN_W'(1));
                    cmd.data  = head;
                    k_next    = k_reg + LEN_W'(1);
                    if (k_is_pos)
                    begin
                        a_next = head;
                        b_next = nb1;
                        c_next = nb2;
                    end
                    if ((strands_reg != 7'd0) && (mh == strands_reg - 7'd1)
                        && (cntb_reg != 2'd2))
                    begin
                        cntb_next = cntb_reg + 2'd1;
                    end
                    if ((mh == 7'd1) && (cntt_reg != 2'd2))
                    begin
                        cntt_next = cntt_reg + 2'd1;
                    end
                    if (mh == 7'd127)
                    begin
                        big_next = 1'b1;
                    end
                end
            end

            S_WORK:
            begin
                if (rq_reg == RQ_LIST)
                begin
                    // one flagged beat per element
                    if (slot_free)
                    begin
                        cmd.shift           = 1'b1;
                        cmd.wr              = 1'b1;
                        cmd.idx             = IDX_W'(len_reg - LEN_W'(1));
                        cmd.data            = head;
                        rsp_valid_next      = 1'b1;
                        rsp_next.status     = ST_OK;
                        rsp_next.flag       = chk(kind_reg, head, nb1, nb2, n_reg,
                                                  strands_reg, cntb_reg, cntt_reg);
                        rsp_next.elem_value = '0;
                        rsp_next.word_length = 7'(len_reg);
                        rsp_next.last       = (k_reg + LEN_W'(1) == n_reg);
                        k_next              = k_reg + LEN_W'(1);
                        if (k_reg + LEN_W'(1) == n_reg)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
                else if (ins_reg < need)
                begin
                    cmd.wr   = 1'b1;
                    cmd.idx  = IDX_W'(len_reg);
                    cmd.data = ins_val;
                    len_next = len_reg + LEN_W'(1);
                    ins_next = ins_reg + 2'd1;
                end
                else if (k_reg == n_reg)
                begin
                    state_next = S_RESP;
                end
                else if (pop)
                begin
                    cmd.shift = 1'b1;
                    len_next  = len_reg - LEN_W'(1);
                    k_next    = k_reg + LEN_W'(1);
                    ins_next  = 2'd0;
                end
                else
                begin
                    cmd.shift = 1'b1;
                    cmd.wr    = 1'b1;
                    cmd.idx   = IDX_W'(len_reg - LEN_W'(1));
                    cmd.data  = rot_val;
                    k_next    = k_reg + LEN_W'(1);
                    ins_next  = 2'd0;
                end
            end

            S_RESP:
            begin
                if (slot_free)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.status      = st_reg;
                    rsp_next.flag        = fl_reg;
                    rsp_next.elem_value  = el_reg;
                    rsp_next.word_length = 7'(len_reg);
                    rsp_next.last        = 1'b1;
                    state_next           = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= '0;
            n_reg         <= '0;
            k_reg         <= '0;
            rc_reg        <= '0;
            ins_reg       <= 2'd0;
            r_reg         <= '0;
            rq_reg        <= RQ_CLEAR;
            pos_reg       <= '0;
            gv_reg        <= '0;
            kind_reg      <= CK_REL1;
            top_reg       <= 1'b0;
            inv_reg       <= 1'b0;
            strands_reg   <= '0;
            st_reg        <= ST_OK;
            fl_reg        <= 1'b0;
            el_reg        <= '0;
            a_reg         <= '0;
            b_reg         <= '0;
            c_reg         <= '0;
            cntb_reg      <= 2'd0;
            cntt_reg      <= 2'd0;
            big_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            n_reg         <= n_next;
            k_reg         <= k_next;
            rc_reg        <= rc_next;
            ins_reg       <= ins_next;
            r_reg         <= r_next;
            rq_reg        <= rq_next;
            pos_reg       <= pos_next;
            gv_reg        <= gv_next;
            kind_reg      <= kind_next;
            top_reg       <= top_next;
            inv_reg       <= inv_next;
            strands_reg   <= strands_next;
            st_reg        <= st_next;
            fl_reg        <= fl_next;
            el_reg        <= el_next;
            a_reg         <= a_next;
            b_reg         <= b_next;
            c_reg         <= c_next;
            cntb_reg      <= cntb_next;
            cntt_reg      <= cntt_next;
            big_reg       <= big_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // word never outgrows the chain
    a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
        EXT_W'(len_reg) <= EXT_W'(MAX_LEN))
        else $error("word length beyond chain capacity");

    // a scan turn leaves the length alone
    a_scan_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |=> (len_reg == $past(len_reg)))
        else $error("length changed during scan");

    // only list beats may be non-final, and they carry no error or element
    a_mid_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.last) |-> ((rsp.status == ST_OK) && (rsp.elem_value == 8'sd0)))
        else $error("bad non-final beat");

    // an accepted request makes the block busy in the next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("request accepted without going busy");

endmodule

// ----- rtl/bwr_cell.sv -----
`timescale 1ns / 1ps
module bwr_cell
    import bwr_pkg::*;
(
    input  logic  clk,
    input  logic  shift,
    input  logic  wr,
    input  elem_t wdata,
    input  elem_t right,
    output elem_t q
);

    elem_t q_reg;

    // load new element, else take the right neighbor on a shift
    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            q_reg <= wdata;
        end
        else if (shift)
        begin
            q_reg <= right;
        end
    end

    assign q = q_reg;

endmodule

// ----- rtl/bwr_chain.sv -----
`timescale 1ns / 1ps
module bwr_chain
    import bwr_pkg::*;
(
    input  logic       clk,
    input  chain_cmd_t cmd,
    output elem_t      head,
    output elem_t      nb1,
    output elem_t      nb2
);

    elem_t q [MAX_LEN];

    // row of cells, element 0 at the head
    for (genvar i = 0; i < MAX_LEN; i++)
    begin : g_cell
        elem_t nbr;
        logic  wr_here;

        if (i == MAX_LEN - 1)
        begin : g_end
            assign nbr = '0;
        end
        else
        begin : g_mid
            assign nbr = q[i+1];
        end

        assign wr_here = cmd.wr && (cmd.idx == IDX_W'(i));

        bwr_cell u_cell (
            .clk   (clk),
            .shift (cmd.shift),
            .wr    (wr_here),
            .wdata (cmd.data),
            .right (nbr),
            .q     (q[i])
        );
    end

    assign head = q[0];
    assign nb1  = q[1];
    assign nb2  = q[2];

endmodule
